### design/c_source_tokenizer_assert.svh
// assertion macros for the tokenizer checker
`ifndef C_SOURCE_TOKENIZER_ASSERT_SVH
`define C_SOURCE_TOKENIZER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/cst_pkg.sv
package cst_pkg;

  localparam int unsigned MaxWordBytes = 8;
  localparam int unsigned NumKeywords = 13;

  typedef enum logic [3:0] {
    TK_TYPESPEC = 4'd0,
    TK_JUMP     = 4'd1,
    TK_IDENT    = 4'd2,
    TK_LINELEN  = 4'd3,
    TK_NEWLINE  = 4'd4,
    TK_SPACE    = 4'd5,
    TK_POUND    = 4'd6,
    TK_LPAREN   = 4'd7,
    TK_RPAREN   = 4'd8,
    TK_LBRACE   = 4'd9,
    TK_RBRACE   = 4'd10,
    TK_EQUAL    = 4'd11,
    TK_SEMI     = 4'd12,
    TK_SLASH    = 4'd13,
    TK_OPERATOR = 4'd14
  } token_kind_t;

  typedef struct packed {
    token_kind_t kind;
    logic [63:0] text;
    logic [7:0]  length;
    logic        truncated;
    logic [15:0] line_chars;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [63:0] store;
    logic [7:0]  count;
    logic [15:0] line;
  } lex_state_t;

  // keyword text packed with the first character in the low byte
  localparam logic [63:0] KwText [NumKeywords] = '{
    64'h0000_0000_6469_6f76,  // void
    64'h0000_0000_7261_6863,  // char
    64'h0000_0074_726f_6873,  // short
    64'h0000_0000_0074_6e69,  // int
    64'h0000_0000_676e_6f6c,  // long
    64'h0000_0074_616f_6c66,  // float
    64'h0000_656c_6275_6f64,  // double
    64'h0000_6465_6e67_6973,  // signed
    64'h6465_6e67_6973_6e75,  // unsigned
    64'h0000_0000_6f74_6f67,  // goto
    64'h6575_6e69_746e_6f63,  // continue
    64'h0000_006b_6165_7262,  // break
    64'h0000_6e72_7574_6572   // return
  };
  localparam logic [7:0] KwLen [NumKeywords] = '{
    8'd4, 8'd4, 8'd5, 8'd3, 8'd4, 8'd5, 8'd6, 8'd6, 8'd8, 8'd4, 8'd8, 8'd5, 8'd6
  };
  localparam logic [NumKeywords-1:0] KwIsJump = 13'b1_1110_0000_0000;

  function automatic token_kind_t word_kind(input logic [63:0] store,
                                            input logic [7:0] count);
    token_kind_t k;
    k = TK_IDENT;
    for (int i = 0; i < NumKeywords; i++) begin
      if (count == KwLen[i] && store == KwText[i]) begin
        k = KwIsJump[i] ? TK_JUMP : TK_TYPESPEC;
      end
    end
    return k;
  endfunction

  function automatic token_kind_t symbol_kind(input logic [7:0] c);
    token_kind_t k;
    unique case (c)
      8'h23:   k = TK_POUND;
      8'h28:   k = TK_LPAREN;
      8'h29:   k = TK_RPAREN;
      8'h7b:   k = TK_LBRACE;
      8'h7d:   k = TK_RBRACE;
      8'h3d:   k = TK_EQUAL;
      8'h3b:   k = TK_SEMI;
      8'h2f:   k = TK_SLASH;
      default: k = TK_OPERATOR;
    endcase
    return k;
  endfunction

endpackage

### design/cst_step.sv
module cst_step import cst_pkg::*; (
  input  logic [7:0]      char_byte,
  input  lex_state_t      state,
  output lex_state_t      state_next,
  output result_t [2:0]   res,
  output logic [1:0]      res_count
);

  logic        is_alnum;
  logic        is_nl;
  logic        is_space;
  logic        is_ignored;
  logic        is_punct;
  logic        flush;
  logic [1:0]  base;
  token_kind_t wkind;
  result_t     flush_rec;
  result_t     rec;

  always_comb begin
    is_alnum   = (char_byte >= 8'h30 && char_byte <= 8'h39) ||
                 (char_byte >= 8'h41 && char_byte <= 8'h5a) ||
                 (char_byte >= 8'h61 && char_byte <= 8'h7a);
    is_nl      = char_byte == 8'h0a;
    is_space   = char_byte == 8'h20;
    is_ignored = char_byte == 8'h09 || char_byte == 8'h0b ||
                 char_byte == 8'h0c || char_byte == 8'h0d;
    is_punct   = !is_alnum && !is_nl && !is_space && !is_ignored;
    flush      = state.count != 8'd0 && (is_nl || is_space || is_punct);

    // long words never match a keyword
    wkind = (state.count > 8'(MaxWordBytes)) ? TK_IDENT
                                             : word_kind(state.store, state.count);

    flush_rec = '0;
    flush_rec.kind = wkind;
    if (wkind == TK_IDENT) begin
      flush_rec.text      = state.store;
      flush_rec.length    = state.count;
      flush_rec.truncated = state.count > 8'(MaxWordBytes);
    end

    state_next = state;
    res        = '0;
    res_count  = 2'd0;
    base       = flush ? 2'd1 : 2'd0;
    if (flush) begin
      res[0]           = flush_rec;
      state_next.store = '0;
      state_next.count = '0;
    end

    rec = '0;
    if (is_nl) begin
      rec.kind        = TK_LINELEN;
      rec.line_chars  = state.line;
      res[base]       = rec;
      rec             = '0;
      rec.kind        = TK_NEWLINE;
      res[base + 2'd1] = rec;
      res_count       = base + 2'd2;
      state_next.line = '0;
    end else begin
      if (state.line != 16'hffff) begin
        state_next.line = state.line + 16'd1;
      end
      if (is_alnum) begin
        if (state.count < 8'(MaxWordBytes)) begin
          state_next.store[8*state.count[2:0] +: 8] = char_byte;
        end
        if (state.count != 8'hff) begin
          state_next.count = state.count + 8'd1;
        end
      end else if (is_space) begin
        rec.kind  = TK_SPACE;
        res[base] = rec;
        res_count = base + 2'd1;
      end else if (is_punct) begin
        rec.kind  = symbol_kind(char_byte);
        res[base] = rec;
        res_count = base + 2'd1;
      end
    end

    if (res_count != 2'd0) begin
      res[res_count - 2'd1].last = 1'b1;
    end
  end

endmodule

### design/c_source_tokenizer.sv
// output: results of a byte are registered and appear in the cycle after it is accepted
// throughput: one byte per cycle while each byte gives at most one token and out_stall is low;
//   a byte that gives several tokens (up to 3) holds the single result port until all of them have left
// rate is set by the three-entry result buffer draining one token per cycle while out_stall is low
// reset: synchronous rst clears the word, the line count and the result buffer
module c_source_tokenizer import cst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // byte channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_byte,
  // token channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  token_kind,
  output logic [63:0] word_text,
  output logic [7:0]  word_length,
  output logic        word_truncated,
  output logic [15:0] line_chars,
  output logic        last_of_run
);

  // lexer state: held word, its length, bytes on the current line
  lex_state_t    state;
  lex_state_t    state_next;

  // tokens of the last accepted byte, head in slot 0
  result_t [2:0] slots;
  logic [1:0]    count;

  result_t [2:0] res;
  logic [1:0]    res_count;
  logic          drain;
  logic          take;

  cst_step u_step (
    .char_byte  (char_byte),
    .state      (state),
    .state_next (state_next),
    .res        (res),
    .res_count  (res_count)
  );

  assign out_valid = count != 2'd0;
  assign drain     = out_valid && !out_stall;
  // a new byte may enter when the buffer is empty or its last token leaves now
  assign in_stall  = !(count == 2'd0 || (count == 2'd1 && drain));
  assign take      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
      count <= 2'd0;
    end else if (take) begin
      state <= state_next;
      count <= res_count;
    end else if (drain) begin
      count <= count - 2'd1;
    end
  end

  // token payload, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      slots <= res;
    end else if (drain) begin
      slots[0] <= slots[1];
      slots[1] <= slots[2];
    end
  end

  assign token_kind     = slots[0].kind;
  assign word_text      = slots[0].text;
  assign word_length    = slots[0].length;
  assign word_truncated = slots[0].truncated;
  assign line_chars     = slots[0].line_chars;
  assign last_of_run    = slots[0].last;

endmodule

### design/cst_checker.sv
`include "c_source_tokenizer_assert.svh"

module cst_checker import cst_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  char_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  token_kind,
  input logic [63:0] word_text,
  input logic [7:0]  word_length,
  input logic        word_truncated,
  input logic [15:0] line_chars,
  input logic        last_of_run
);

  `CST_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(char_byte), "stalled byte changed")
  `CST_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(token_kind) && $stable(last_of_run), "stalled token changed")
  `CST_ASSERT_NOW(a_word_fields, out_valid && token_kind != TK_IDENT, word_text == 64'd0 && word_length == 8'd0 && !word_truncated, "word fields set on non-identifier")
  `CST_ASSERT_NOW(a_line_field, out_valid && token_kind != TK_LINELEN, line_chars == 16'd0, "line length set on wrong token")
  `CST_ASSERT_NEXT(a_nl_follows, out_valid && !out_stall && token_kind == TK_LINELEN, out_valid && token_kind == TK_NEWLINE && last_of_run, "line length not followed by final newline")

endmodule

bind c_source_tokenizer cst_checker u_cst_checker (.*);
